@@ rtl/demand_paging_lru_mmu_macros.svh @@
// Assertion helpers for the paging MMU
`ifndef DEMAND_PAGING_LRU_MMU_MACROS_SVH
`define DEMAND_PAGING_LRU_MMU_MACROS_SVH
// implication checked at every edge outside reset
`define DPL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// condition that must hold at every edge outside reset
`define DPL_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: check failed");
`endif

@@ rtl/dplm_pkg.sv @@
// ----------------------------------------------------------------------------
// dplm_pkg
// Types, constants and codes shared by the paging MMU modules.
// ----------------------------------------------------------------------------
package dplm_pkg;
  localparam int NUM_PAGES_DEF  = 128;
  localparam int NUM_FRAMES_DEF = 16;
  localparam int PAGE_BYTES_DEF = 32;

  localparam int TEXT_W = 8;
  localparam int VADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int PHYS_W = 9;
  localparam int PAGE_W = 7;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_RO    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EVICT,
    S_SHIFT,
    S_APPEND,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic look;
    logic evict;
    logic shift;
    logic append;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic hit;
    logic free_found;
    logic shift_done;
  } sts_t;
endpackage

@@ rtl/dplm_ctrl.sv @@
// ----------------------------------------------------------------------------
// dplm_ctrl
// Request sequencer: lookup, then output on an error, else optional eviction, LRU shift, append, output.
// ----------------------------------------------------------------------------
module dplm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output dplm_pkg::cmd_t  cmd,
  input  dplm_pkg::sts_t  sts
);
  import dplm_pkg::*;
`include "demand_paging_lru_mmu_macros.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_LOOK;
      S_LOOK: begin
        if (sts.early) state_nxt = S_OUT;
        else if (sts.hit || sts.free_found) state_nxt = S_SHIFT;
        else state_nxt = S_EVICT;
      end
      S_EVICT:  state_nxt = S_SHIFT;
      S_SHIFT:  if (sts.shift_done) state_nxt = S_APPEND;
      S_APPEND: state_nxt = S_OUT;
      S_OUT:    if (out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && in_tvalid;
    cmd.look   = (state_r == S_LOOK);
    cmd.evict  = (state_r == S_EVICT);
    cmd.shift  = (state_r == S_SHIFT);
    cmd.append = (state_r == S_APPEND);
    cmd.finish = (state_r == S_OUT) && out_tready;
  end

  `DPL_ASSERT_ALWAYS(a_excl, !(in_tready && out_tvalid))
  `DPL_ASSERT_IMP(a_load_look, cmd.load, ##1 state_r == S_LOOK)
  `DPL_ASSERT_IMP(a_evict_shift, state_r == S_EVICT, ##1 state_r == S_SHIFT)
endmodule

@@ rtl/dplm_datapath.sv @@
// ----------------------------------------------------------------------------
// dplm_datapath
// Page table, frame map, LRU list and result registers.
// ----------------------------------------------------------------------------
module dplm_datapath #(
  parameter int NUM_PAGES  = dplm_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = dplm_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BYTES = dplm_pkg::PAGE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [dplm_pkg::TEXT_W-1:0]     text_pages,
  input  logic                            req_type,
  input  logic [dplm_pkg::VADDR_W-1:0]    virt_address,
  input  logic [dplm_pkg::BYTE_W-1:0]     store_byte,
  input  dplm_pkg::cmd_t                  cmd,
  output dplm_pkg::sts_t                  sts,
  output logic [1:0]                      status,
  output logic [dplm_pkg::PHYS_W-1:0]     phys_address,
  output logic                            write_enable,
  output logic [dplm_pkg::BYTE_W-1:0]     write_byte,
  output logic                            fill_needed,
  output logic [dplm_pkg::PAGE_W-1:0]     fill_page,
  output logic                            fill_from_swap,
  output logic                            writeback_needed,
  output logic [dplm_pkg::PAGE_W-1:0]     writeback_page
);
  import dplm_pkg::*;
`include "demand_paging_lru_mmu_macros.svh"

  localparam int PW = $clog2(NUM_PAGES);
  localparam int FW = $clog2(NUM_FRAMES);
  localparam int OW = $clog2(PAGE_BYTES);
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int SPACE = NUM_PAGES * PAGE_BYTES;

  logic [NUM_PAGES-1:0]  valid_r, dirty_r, swap_r;
  logic [FW-1:0]         frame_mem [NUM_PAGES];
  logic [NUM_FRAMES-1:0] used_r;
  logic [PW-1:0]         lru_r [NUM_FRAMES];
  logic [CW-1:0]         cnt_r;

  logic              st_r;
  logic [PW-1:0]     page_r;
  logic [OW-1:0]     off_r;
  logic [BYTE_W-1:0] data_r;
  logic              range_r;
  logic [FW-1:0]     frame_r;
  logic              hit_r;
  logic [CW-1:0]     idx_r;
  logic [PW-1:0]     victim_r;
  logic              wb_r;
  logic [FW-1:0]     rd_frame_r;

  logic [1:0]        status_r;
  logic              fill_r;

  logic [VADDR_W-1:0] space_c;
  logic              in_range_c;
  logic              early_c;
  logic              free_c;
  logic [FW-1:0]     free_idx_c;
  logic [CW-1:0]     pos_c;
  logic [FW-1:0]     hit_frame_c;

  assign space_c = VADDR_W'(SPACE);

  always_comb begin
    free_c = 1'b0;
    free_idx_c = '0;
    for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
      if (!used_r[f]) begin
        free_c = 1'b1;
        free_idx_c = FW'(f);
      end
    end
  end

  always_comb begin
    pos_c = cnt_r;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if ((CW'(i) < cnt_r) && (lru_r[i] == page_r)) pos_c = CW'(i);
    end
  end

  assign in_range_c  = (SPACE >= (1 << VADDR_W)) || !range_r;
  assign early_c     = !in_range_c || (st_r && ({{(16-PW){1'b0}}, page_r} <
                       {8'd0, text_pages}));
  assign hit_frame_c = rd_frame_r;

  assign sts.early      = early_c;
  assign sts.hit        = valid_r[page_r];
  assign sts.free_found = free_c;
  assign sts.shift_done = (idx_r + CW'(1) >= cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_r    <= req_type;
      page_r  <= PW'(virt_address >> OW);
      off_r   <= virt_address[OW-1:0];
      data_r  <= store_byte;
      range_r <= (virt_address >= space_c);
    end
    // request page frame during lookup, LRU head frame during eviction
    rd_frame_r <= frame_mem[cmd.load ? PW'(virt_address >> OW) :
                            (cmd.look ? lru_r[0] : page_r)];
    if (cmd.look) begin
      hit_r    <= valid_r[page_r];
      wb_r     <= 1'b0;
      victim_r <= lru_r[0];
      if (valid_r[page_r]) begin
        idx_r <= pos_c;
      end else begin
        idx_r <= free_c ? cnt_r : CW'(0);
        frame_r <= free_idx_c;
      end
    end
    if (cmd.evict) begin
      frame_r <= rd_frame_r;
      wb_r    <= dirty_r[victim_r];
    end
    if (cmd.look && valid_r[page_r]) frame_r <= hit_frame_c;
    if (cmd.shift) begin
      if (idx_r + CW'(1) < cnt_r) begin
        lru_r[idx_r[FW-1:0]] <= lru_r[idx_r[FW-1:0] + FW'(1)];
        idx_r <= idx_r + CW'(1);
      end
    end
    if (cmd.append) begin
      if (hit_r) lru_r[FW'(cnt_r - CW'(1))] <= page_r;
      else if (wb_r || !free_c || cnt_r == CW'(NUM_FRAMES))
        lru_r[FW'(cnt_r - CW'(1))] <= page_r;
      else lru_r[cnt_r[FW-1:0]] <= page_r;
    end
    if (cmd.append && !hit_r) frame_mem[page_r] <= frame_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      swap_r  <= '0;
      used_r  <= '0;
      cnt_r   <= '0;
      status_r <= ST_HIT;
      fill_r  <= 1'b0;
    end else begin
      if (cmd.look) begin
        if (early_c) status_r <= !in_range_c ? ST_RANGE : ST_RO;
        else status_r <= valid_r[page_r] ? ST_HIT : ST_MISS;
        fill_r <= !early_c && !valid_r[page_r];
      end
      if (cmd.evict) begin
        valid_r[victim_r] <= 1'b0;
        if (dirty_r[victim_r]) begin
          dirty_r[victim_r] <= 1'b0;
          swap_r[victim_r]  <= 1'b1;
        end
      end
      if (cmd.append) begin
        if (!hit_r) begin
          used_r[frame_r]  <= 1'b1;
          valid_r[page_r]  <= 1'b1;
          if (cnt_r < CW'(NUM_FRAMES)) cnt_r <= cnt_r + CW'(1);
        end
        if (st_r) dirty_r[page_r] <= 1'b1;
      end
    end
  end

  always_comb begin
    status = status_r;
    phys_address = '0;
    write_enable = 1'b0;
    write_byte = '0;
    fill_needed = 1'b0;
    fill_page = '0;
    fill_from_swap = 1'b0;
    writeback_needed = 1'b0;
    writeback_page = '0;
    if (status_r == ST_HIT || status_r == ST_MISS) begin
      phys_address = PHYS_W'({frame_r, off_r});
      write_enable = st_r;
      write_byte   = st_r ? data_r : '0;
    end
    if (fill_r) begin
      fill_needed    = 1'b1;
      fill_page      = PAGE_W'(page_r);
      fill_from_swap = swap_r[page_r];
      writeback_needed = wb_r;
      writeback_page   = wb_r ? PAGE_W'(victim_r) : '0;
    end
  end

  `DPL_ASSERT_ALWAYS(a_cnt_max, cnt_r <= CW'(NUM_FRAMES))
  `DPL_ASSERT_IMP(a_evict_valid, cmd.evict, valid_r[victim_r])
  `DPL_ASSERT_IMP(a_wb_fill, cmd.finish && wb_r && fill_r, swap_r[victim_r])
endmodule

@@ rtl/demand_paging_lru_mmu.sv @@
// Sequence: a range or read-only error goes from lookup straight to the result; a hit or
// free-frame miss adds LRU shift and append, and an eviction adds an evict step before them.
// One request at a time; the serial LRU shift moves 0..15 entries, one entry per cycle.
// Reset (rst_n low, synchronous) clears page flags, frame-used flags, LRU count and text_pages.
// ----------------------------------------------------------------------------
// demand_paging_lru_mmu
// Demand-paged address translation with LRU page replacement.
// ----------------------------------------------------------------------------
module demand_paging_lru_mmu #(
  parameter int NUM_PAGES  = dplm_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = dplm_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BYTES = dplm_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // virt_address[15:0], store_byte[23:16]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], phys_address[10:2], write_enable[11],
                                  // write_byte[19:12], fill_needed[20], fill_page[27:21],
                                  // fill_from_swap[28], writeback_needed[29],
                                  // writeback_page[36:30], zero[39:37]
);
  import dplm_pkg::*;

  logic [TEXT_W-1:0] text_r;
  cmd_t cmd;
  sts_t sts;
  logic [1:0] status;
  logic [PHYS_W-1:0] phys_address;
  logic write_enable, fill_needed, fill_from_swap, writeback_needed;
  logic [BYTE_W-1:0] write_byte;
  logic [PAGE_W-1:0] fill_page, writeback_page;

  always_ff @(posedge clk) begin
    if (!rst_n) text_r <= '0;
    else if (cfg_we) text_r <= cfg_wdata;
  end

  dplm_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd, .sts
  );

  dplm_datapath #(
    .NUM_PAGES(NUM_PAGES), .NUM_FRAMES(NUM_FRAMES), .PAGE_BYTES(PAGE_BYTES)
  ) u_dp (
    .clk, .rst_n, .text_pages(text_r), .req_type(in_tuser),
    .virt_address(in_tdata[15:0]), .store_byte(in_tdata[23:16]), .cmd, .sts,
    .status, .phys_address, .write_enable, .write_byte, .fill_needed, .fill_page,
    .fill_from_swap, .writeback_needed, .writeback_page
  );

  assign out_tdata = {3'b000, writeback_page, writeback_needed, fill_from_swap, fill_page,
                      fill_needed, write_byte, write_enable, phys_address, status};
endmodule
